>>> hw/rtl/profiled_ramp_value_generator_macros.svh
// ----------------------------------------------------------------------------
// Ramp generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PROFILED_RAMP_VALUE_GENERATOR_MACROS_SVH
`define PROFILED_RAMP_VALUE_GENERATOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PRVG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define PRVG_ASSERT_NEXT(name, pre, post, msg) \
  `PRVG_ASSERT(name, (pre) |=> (post), msg)

`endif

>>> hw/rtl/prvg_pkg.sv
// ----------------------------------------------------------------------------
// Ramp generator package
// Widths, codes and helper functions shared by the ramp generator files.
// ----------------------------------------------------------------------------
package prvg_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Output phase codes.
  typedef enum logic [1:0] {
    PHASE_BEFORE = 2'd0,
    PHASE_RAMP   = 2'd1,
    PHASE_AFTER  = 2'd2
  } phase_e;

  // Profile mode codes; the unused code behaves as smootherstep.
  typedef enum logic [1:0] {
    MODE_LINEAR   = 2'd0,
    MODE_SMOOTH   = 2'd1,
    MODE_SMOOTHER = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_START   = 3'd0,
    REG_RAMP_END     = 3'd1,
    REG_PROFILE_MODE = 3'd2,
    REG_TARGET_ZERO  = 3'd3,
    REG_TARGET_ONE   = 3'd4,
    REG_TARGET_TWO   = 3'd5,
    REG_TARGET_THREE = 3'd6
  } cfg_reg_e;

  // Clamp a 35-bit signed value into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -35'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/prvg_if.sv
// ----------------------------------------------------------------------------
// Ramp generator channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------

// Input item channel.
interface prvg_in_if import prvg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        now_tick;
  logic [1:0]               target_index;
  logic signed [DATA_W-1:0] prior_value;

  modport source (output valid, now_tick, target_index, prior_value, input ready);
  modport sink   (input valid, now_tick, target_index, prior_value, output ready);
endinterface

// Result channel.
interface prvg_out_if import prvg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] ramp_value;
  logic signed [DATA_W-1:0] ramp_slope;
  logic [1:0]               ramp_phase;

  modport source (output valid, ramp_value, ramp_slope, ramp_phase, input ready);
  modport sink   (input valid, ramp_value, ramp_slope, ramp_phase, output ready);
endinterface

// Register write channel.
interface prvg_cfg_if import prvg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/profiled_ramp_value_generator.sv
// ----------------------------------------------------------------------------
// Profiled ramp value generator
// Blends a prior value toward a selected target over a tick window using a
// linear, smoothstep or smootherstep profile, and reports the slope per tick.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the result side stalls, and
// returns one result per item, in order, through the input stage, the ramp
// fraction divider, four power stages, the profile stage, the product stage,
// the slope divider and the output register. Each divider retires one quotient
// bit per stage (31 stages for the ramp fraction, 33 for the slope). A stall
// on the result side holds the whole pipeline. Registers must be written only
// while no transaction is in flight; the block itself does not enforce this.

`include "profiled_ramp_value_generator_macros.svh"

module profiled_ramp_value_generator import prvg_pkg::*; #(
  parameter int unsigned TARGET_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  prvg_in_if.sink        in_i,
  prvg_out_if.source     out_o,
  prvg_cfg_if.sink       cfg_i
);

  localparam int unsigned F_W = 31;
  localparam int unsigned N_W = 33;
  localparam logic signed [37:0] P_LIM = 38'sh0_8000_0000;
  localparam logic signed [37:0] G_LIM = 38'sh1_0000_0000;

  typedef struct packed {
    phase_e                   phase;
    logic signed [DATA_W-1:0] prior;
    logic signed [DATA_W-1:0] target;
    logic [DATA_W-1:0]        mag;
    logic                     neg;
    logic [DATA_W-1:0]        dur;
  } ramp_side_t;

  typedef struct packed {
    phase_e                   phase;
    logic signed [DATA_W-1:0] value;
    logic                     neg;
  } slope_side_t;

  // Configuration registers.
  logic [DATA_W-1:0]        start_q;
  logic [DATA_W-1:0]        end_q;
  logic [1:0]               mode_q;
  logic signed [DATA_W-1:0] target_q [TARGET_COUNT];

  logic en;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      mode_q  <= MODE_SMOOTHER;
      for (int i = 0; i < TARGET_COUNT; i++) begin
        target_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_RAMP_START:   start_q <= cfg_i.data;
        REG_RAMP_END:     end_q   <= cfg_i.data;
        REG_PROFILE_MODE: mode_q  <= cfg_i.data[1:0];
        default: begin
          for (int i = 0; i < TARGET_COUNT; i++) begin
            if (cfg_i.index == CFG_IDX_W'(int'(REG_TARGET_ZERO) + i)) begin
              target_q[i] <= cfg_i.data;
            end
          end
        end
      endcase
    end
  end

  // Input stage: phase decision, target select and blend distance.
  logic [1:0]               idx_sat;
  logic signed [DATA_W-1:0] tgt_sel;
  logic signed [DATA_W:0]   delta;
  ramp_side_t               a_d;
  ramp_side_t               a_q;
  logic [DATA_W-1:0]        pos_d;
  logic [DATA_W-1:0]        pos_q;
  logic                     a_valid_q;

  always_comb begin
    if (int'(in_i.target_index) >= TARGET_COUNT) begin
      idx_sat = 2'(TARGET_COUNT - 1);
    end else begin
      idx_sat = in_i.target_index;
    end
    tgt_sel = target_q[0];
    for (int i = 0; i < TARGET_COUNT; i++) begin
      if (idx_sat == 2'(i)) begin
        tgt_sel = target_q[i];
      end
    end
    delta = {tgt_sel[DATA_W-1], tgt_sel} - {in_i.prior_value[DATA_W-1], in_i.prior_value};
    a_d.prior  = in_i.prior_value;
    a_d.target = tgt_sel;
    a_d.neg    = delta[DATA_W];
    a_d.mag    = delta[DATA_W] ? DATA_W'(-delta) : delta[DATA_W-1:0];
    if (in_i.now_tick < start_q) begin
      a_d.phase = PHASE_BEFORE;
    end else if (in_i.now_tick >= end_q) begin
      a_d.phase = PHASE_AFTER;
    end else begin
      a_d.phase = PHASE_RAMP;
    end
    // Items outside the ramp use a zero position and a duration of one to keep the dividers tidy.
    if (a_d.phase == PHASE_RAMP) begin
      a_d.dur = end_q - start_q;
      pos_d   = in_i.now_tick - start_q;
    end else begin
      a_d.dur = DATA_W'(1);
      pos_d   = '0;
    end
  end

  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      pos_q <= pos_d;
    end
  end

  // Ramp fraction f = pos * 2^31 / dur.
  logic             d1_valid;
  logic [F_W-1:0]   f_div;
  logic [$bits(ramp_side_t)-1:0] d1_side;

  prvg_div #(
    .DW (DATA_W),
    .QW (F_W),
    .SW ($bits(ramp_side_t))
  ) u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid_q),
    .rem_i   (pos_q),
    .num_i   ('0),
    .den_i   (a_q.dur),
    .side_i  (a_q),
    .valid_o (d1_valid),
    .quo_o   (f_div),
    .side_o  (d1_side)
  );

  // Power stages: one product of f per stage.
  logic           m_valid_q [4];
  ramp_side_t     m_side_q  [4];
  logic [F_W-1:0] m_f_q     [4];
  logic [F_W-1:0] f2_q, f3_q, f4_q, f5_q;
  logic [2*F_W-1:0] prod1, prod2, prod3, prod4;

  assign prod1 = (2*F_W)'(f_div) * (2*F_W)'(f_div);
  assign prod2 = (2*F_W)'(f2_q) * (2*F_W)'(m_f_q[0]);
  assign prod3 = (2*F_W)'(f3_q) * (2*F_W)'(m_f_q[1]);
  assign prod4 = (2*F_W)'(f4_q) * (2*F_W)'(m_f_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        m_valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      m_valid_q[0] <= d1_valid;
      for (int i = 1; i < 4; i++) begin
        m_valid_q[i] <= m_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q[0] <= d1_side;
      m_f_q[0]    <= f_div;
      for (int i = 1; i < 4; i++) begin
        m_side_q[i] <= m_side_q[i-1];
        m_f_q[i]    <= m_f_q[i-1];
      end
      f2_q <= prod1[2*F_W-1:F_W];
      f3_q <= prod2[2*F_W-1:F_W];
      f4_q <= prod3[2*F_W-1:F_W];
      f5_q <= prod4[2*F_W-1:F_W];
    end
  end

  // The powers travel with the item; keep aligned copies of the lower ones
  // so that all of them reach the last power stage together with f^5.
  logic [F_W-1:0] f2_d1_q, f2_d2_q, f2_d3_q, f3_d1_q, f3_d2_q, f4_d1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_d1_q <= f2_q;
      f2_d2_q <= f2_d1_q;
      f2_d3_q <= f2_d2_q;
      f3_d1_q <= f3_q;
      f3_d2_q <= f3_d1_q;
      f4_d1_q <= f4_q;
    end
  end

  // Profile stage: p(f) and its derivative, clamped.
  logic signed [37:0] fs, f2s, f3s, f4s, f5s, p_s, g_s;
  logic [DATA_W-1:0]  p_d, p_q;
  logic [DATA_W:0]    g_d, g_q;
  logic               p_valid_q;
  ramp_side_t         p_side_q;

  always_comb begin
    fs  = 38'(m_f_q[3]);
    f2s = 38'(f2_d3_q);
    f3s = 38'(f3_d2_q);
    f4s = 38'(f4_d1_q);
    f5s = 38'(f5_q);
    case (mode_q)
      MODE_LINEAR: begin
        p_s = fs;
        g_s = P_LIM;
      end
      MODE_SMOOTH: begin
        p_s = 38'sd3 * f2s - 38'sd2 * f3s;
        g_s = 38'sd6 * (fs - f2s);
      end
      default: begin
        p_s = 38'sd6 * f5s - 38'sd15 * f4s + 38'sd10 * f3s;
        g_s = 38'sd30 * (f2s - 38'sd2 * f3s + f4s);
      end
    endcase
    if (p_s < 0) begin
      p_d = '0;
    end else if (p_s > P_LIM) begin
      p_d = P_LIM[DATA_W-1:0];
    end else begin
      p_d = p_s[DATA_W-1:0];
    end
    if (g_s < 0) begin
      g_d = '0;
    end else if (g_s > G_LIM) begin
      g_d = G_LIM[DATA_W:0];
    end else begin
      g_d = g_s[DATA_W:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= m_valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q      <= p_d;
      g_q      <= g_d;
      p_side_q <= m_side_q[3];
    end
  end

  // Product stage: value step and slope numerator.
  logic [63:0]       prod_p;
  logic [64:0]       prod_g;
  logic [DATA_W-1:0] vm_q;
  logic [N_W-1:0]    n_q;
  logic              v_valid_q;
  ramp_side_t        v_side_q;

  assign prod_p = 64'(p_side_q.mag) * 64'(p_q);
  assign prod_g = 65'(p_side_q.mag) * 65'(g_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
    end else if (en) begin
      v_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vm_q     <= prod_p[62:31];
      n_q      <= prod_g[63:31];
      v_side_q <= p_side_q;
    end
  end

  // Blended value, chosen by phase, rides along the slope divider.
  logic signed [34:0] vsum;
  slope_side_t        s_d;

  always_comb begin
    if (v_side_q.neg) begin
      vsum = 35'(v_side_q.prior) - $signed({3'b0, vm_q});
    end else begin
      vsum = 35'(v_side_q.prior) + $signed({3'b0, vm_q});
    end
    s_d.phase = v_side_q.phase;
    s_d.neg   = v_side_q.neg;
    case (v_side_q.phase)
      PHASE_BEFORE: s_d.value = v_side_q.prior;
      PHASE_AFTER:  s_d.value = v_side_q.target;
      default:      s_d.value = sat32(vsum);
    endcase
  end

  // Slope magnitude = floor(mag * g / 2^31) / dur.
  logic           d2_valid;
  logic [N_W-1:0] q_div;
  logic [$bits(slope_side_t)-1:0] d2_side_raw;
  slope_side_t    d2_side;

  prvg_div #(
    .DW (DATA_W),
    .QW (N_W),
    .SW ($bits(slope_side_t))
  ) u_slope_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_valid_q),
    .rem_i   ('0),
    .num_i   (n_q),
    .den_i   (v_side_q.dur),
    .side_i  (s_d),
    .valid_o (d2_valid),
    .quo_o   (q_div),
    .side_o  (d2_side_raw)
  );

  assign d2_side = d2_side_raw;

  // Output register with signed saturation of the slope.
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] slope_d, slope_q;
  logic [1:0]               phase_q;
  logic                     q_big;

  assign q_big = (q_div[N_W-1:DATA_W-1] != '0);

  always_comb begin
    if (d2_side.phase != PHASE_RAMP) begin
      slope_d = '0;
    end else if (d2_side.neg) begin
      slope_d = q_big ? 32'sh8000_0000 : -$signed(q_div[DATA_W-1:0]);
    end else begin
      slope_d = q_big ? 32'sh7FFF_FFFF : $signed(q_div[DATA_W-1:0]);
    end
  end

  assign en = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= d2_side.value;
      slope_q <= slope_d;
      phase_q <= d2_side.phase;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ramp_value = value_q;
  assign out_o.ramp_slope = slope_q;
  assign out_o.ramp_phase = phase_q;

  // Outside the ramp the slope is always zero.
  `PRVG_ASSERT(a_flat_slope,
               out_valid_q && (phase_q != PHASE_RAMP) |-> (slope_q == '0),
               "nonzero slope outside the ramp")
  // The clamped profile stays within one and its derivative within two.
  `PRVG_ASSERT(a_profile_clamp,
               p_valid_q |-> (p_q <= P_LIM[DATA_W-1:0]) && (g_q <= G_LIM[DATA_W:0]),
               "profile value or derivative out of range")
  // Squaring a fraction below one never grows it.
  `PRVG_ASSERT(a_power_order, m_valid_q[0] |-> (f2_q <= m_f_q[0]),
               "square of the ramp fraction exceeds the fraction")

endmodule

>>> hw/rtl/prvg_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; a sideband word travels alongside.
// ----------------------------------------------------------------------------
`include "profiled_ramp_value_generator_macros.svh"

module prvg_div import prvg_pkg::*; #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 31,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] num_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] num_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next numerator bit and try a subtraction.
    assign rem_sh = {rem_in, num_in[QW-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(rem_sh - {1'b0, den_in}) : DW'(rem_sh);
        num_q[k]  <= num_in << 1;
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

  // The partial remainder leaving the last stage is below the divisor.
  `PRVG_ASSERT(a_rem_below_den, valid_o |-> (rem_q[QW-1] < den_q[QW-1]),
               "divider remainder not below divisor")
  // A zero divisor never reaches the end of the pipeline.
  `PRVG_ASSERT(a_den_nonzero, valid_o |-> (den_q[QW-1] != '0),
               "divider saw a zero divisor")
  // A stalled pipeline keeps its last stage.
  `PRVG_ASSERT_NEXT(a_stall_holds, !en_i, $stable(valid_o) && $stable(quo_o),
                    "divider output moved during a stall")

endmodule

>>> test/tb_profiled_ramp_value_generator.sv
// ----------------------------------------------------------------------------
// Ramp generator testbench
// Drives timed items through the ramp generator under random flow control,
// predicts value, slope and phase per item and checks results in order.
// ----------------------------------------------------------------------------

// Tracks expected results and compares them with what the block returns.
class ramp_scoreboard;
  logic [31:0] start_tick;
  logic [31:0] end_tick;
  logic [1:0]  mode;
  logic signed [31:0] targets [4];

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic [1:0]         phase;
  } ramp_result_t;

  ramp_result_t pending_results [$];
  int errors;
  int checked;

  function new();
    start_tick = 0;
    end_tick   = 0;
    mode       = prvg_pkg::MODE_SMOOTHER;
    foreach (targets[i]) targets[i] = 0;
    errors  = 0;
    checked = 0;
  endfunction

  function void write_reg(prvg_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      prvg_pkg::REG_RAMP_START:   start_tick = data;
      prvg_pkg::REG_RAMP_END:     end_tick = data;
      prvg_pkg::REG_PROFILE_MODE: mode = data[1:0];
      prvg_pkg::REG_TARGET_ZERO:  targets[0] = data;
      prvg_pkg::REG_TARGET_ONE:   targets[1] = data;
      prvg_pkg::REG_TARGET_TWO:   targets[2] = data;
      prvg_pkg::REG_TARGET_THREE: targets[3] = data;
      default: ;
    endcase
  endfunction

  static function logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Computes the blended value, slope and phase for one accepted item.
  function void note_item(logic [31:0] now, logic [1:0] idx, logic signed [31:0] prior);
    ramp_result_t r;
    longint target, delta, pr, g, value, slope;
    logic [63:0] dur, pos, f, f2, f3, f4, f5, mag;
    logic [127:0] vm, sm;
    bit neg;
    target = targets[idx];
    if (now < start_tick) begin
      r.value = prior; r.slope = 0; r.phase = prvg_pkg::PHASE_BEFORE;
    end else if (now >= end_tick) begin
      r.value = target; r.slope = 0; r.phase = prvg_pkg::PHASE_AFTER;
    end else begin
      dur = end_tick - start_tick;
      pos = now - start_tick;
      f  = (pos << 31) / dur;
      f2 = (f * f) >> 31;
      f3 = (f2 * f) >> 31;
      f4 = (f3 * f) >> 31;
      f5 = (f4 * f) >> 31;
      if (mode == prvg_pkg::MODE_LINEAR) begin
        pr = f; g = 64'sd1 << 31;
      end else if (mode == prvg_pkg::MODE_SMOOTH) begin
        pr = 3 * longint'(f2) - 2 * longint'(f3);
        g  = 6 * (longint'(f) - longint'(f2));
      end else begin
        pr = 6 * longint'(f5) - 15 * longint'(f4) + 10 * longint'(f3);
        g  = 30 * (longint'(f2) - 2 * longint'(f3) + longint'(f4));
      end
      if (pr < 0) pr = 0;
      if (pr > (64'sd1 << 31)) pr = 64'sd1 << 31;
      if (g < 0) g = 0;
      if (g > (64'sd1 << 32)) g = 64'sd1 << 32;
      delta = target - longint'(prior);
      neg = delta < 0;
      mag = neg ? -delta : delta;
      vm = (128'(mag) * 128'(pr)) >> 31;
      sm = (128'(mag) * 128'(g)) / (128'(dur) << 31);
      value = neg ? longint'(prior) - longint'(vm) : longint'(prior) + longint'(vm);
      slope = neg ? -longint'(sm) : longint'(sm);
      r.value = clip32(value);
      r.slope = clip32(slope);
      r.phase = prvg_pkg::PHASE_RAMP;
    end
    pending_results.insert(pending_results.size(), r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at %0t: got %h want %h", what, $time, got, want);
    errors++;
  endtask

  // Compares one returned result with the oldest expectation.
  task check_result(logic signed [31:0] v, logic signed [31:0] s, logic [1:0] p);
    ramp_result_t e;
    checked++;
    if (pending_results.size() == 0) begin
      report("unexpected result", v, 0);
      return;
    end
    e = pending_results.pop_front();
    if (v !== e.value) report("ramp_value", v, e.value);
    if (s !== e.slope) report("ramp_slope", s, e.slope);
    if (p !== e.phase) report("ramp_phase", p, e.phase);
  endtask
endclass

module tb_profiled_ramp_value_generator;
  import prvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 5000;

  logic clk_i;
  logic rst_ni;
  int   idle_cycles;
  bit   hold_off;
  int   ramp_items;

  prvg_in_if  in_ch();
  prvg_out_if out_ch();
  prvg_cfg_if cfg_ch();

  ramp_scoreboard sb;

  profiled_ramp_value_generator i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Writes one register and records it in the predictor.
  task automatic write_cfg(cfg_reg_e idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sends one input item and notes it once accepted; valid stays high
  // afterwards so that items without a gap follow back to back.
  task automatic send_item(logic [31:0] now, logic [1:0] idx, logic [31:0] prior, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.now_tick     <= now;
    in_ch.target_index <= idx;
    in_ch.prior_value  <= prior;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(now, idx, prior);
    if (now >= sb.start_tick && now < sb.end_tick) ramp_items++;
    @(negedge clk_i);
  endtask

  // Stops offering items, waits for all results, then lets the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_targets();
    write_cfg(REG_TARGET_ZERO, $urandom());
    write_cfg(REG_TARGET_ONE, $urandom());
    write_cfg(REG_TARGET_TWO, $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
    write_cfg(REG_TARGET_THREE, $urandom() >> $urandom_range(0, 31));
  endtask

  // Tick near the configured window, with some far-off values.
  function automatic logic [31:0] pick_tick();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return sb.start_tick - $urandom_range(0, 3);
    if (r == 2) return sb.end_tick + $urandom_range(0, 3) - 1;
    return sb.start_tick + $urandom_range(0, sb.end_tick - sb.start_tick);
  endfunction

  // Result side: random stalls plus one long hold-off.
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else begin
        g = gap_len();
        if (g != 0 && $urandom_range(0, 3) == 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.ramp_value, out_ch.ramp_slope, out_ch.ramp_phase);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("tb_profiled_ramp_value_generator: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main stimulus.
  initial begin
    logic [31:0] s, d;
    sb = new();
    idle_cycles = 0;
    hold_off = 0;
    ramp_items = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.now_tick = '0;
    in_ch.target_index = '0;
    in_ch.prior_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RAMP_START;
    cfg_ch.data = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: start equals end, every tick is past the end.
    send_item(32'd0, 2'd0, 32'h1234_5678, 0);
    send_item(32'hFFFF_FFFF, 2'd3, 32'h8000_0000, 0);
    drain();

    // Directed window with extreme targets in every profile mode.
    write_cfg(REG_RAMP_START, 32'd100);
    write_cfg(REG_RAMP_END, 32'd200);
    write_cfg(REG_TARGET_ZERO, 32'h7FFF_FFFF);
    write_cfg(REG_TARGET_ONE, 32'h8000_0000);
    write_cfg(REG_TARGET_TWO, 32'h0001_0000);
    write_cfg(REG_TARGET_THREE, 32'hFFFF_0000);
    for (int m = 0; m < 4; m++) begin
      write_cfg(REG_PROFILE_MODE, m);
      send_item(32'd99, 2'd0, 32'h8000_0000, 0);
      send_item(32'd100, 2'd0, 32'h8000_0000, 0);
      send_item(32'd150, 2'd1, 32'h7FFF_FFFF, 0);
      send_item(32'd199, m[1:0], 32'h0000_0000, 0);
      send_item(32'd200, 2'd2, 32'hFFFF_FFFF, 0);
      drain();
    end

    // Start after end, and the widest window.
    write_cfg(REG_RAMP_START, 32'd500);
    write_cfg(REG_RAMP_END, 32'd10);
    send_item(32'd499, 2'd1, 32'h5555_5555, 0);
    send_item(32'd500, 2'd1, 32'h5555_5555, 0);
    drain();
    write_cfg(REG_RAMP_START, 32'd0);
    write_cfg(REG_RAMP_END, 32'hFFFF_FFFF);
    send_item(32'd1, 2'd0, 32'h8000_0000, 0);
    send_item(32'hFFFF_FFFE, 2'd1, 32'h7FFF_FFFF, 0);
    drain();

    // Random phases: new settings, then random items with random gaps.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin s = $urandom_range(0, 1000); d = $urandom_range(1, 8); end
        1: begin s = $urandom(); d = $urandom_range(1, 4000); end
        2: begin s = $urandom_range(0, 50); d = $urandom() >> $urandom_range(0, 8); end
        default: begin s = $urandom(); d = 32'hFFFF_FFFF - s; end
      endcase
      if (32'hFFFF_FFFF - s < d) d = 32'hFFFF_FFFF - s;
      write_cfg(REG_RAMP_START, s);
      write_cfg(REG_RAMP_END, s + d);
      write_cfg(REG_PROFILE_MODE, $urandom_range(0, 3));
      random_targets();
      if (ph == 5) begin
        // Long receiver hold-off while items keep coming.
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int k = 0; k < 80; k++) begin
        send_item(pick_tick(), $urandom_range(0, 3), $urandom(), ph != 5);
      end
      drain();
    end

    $display("Covered all profile modes, empty and reversed windows, extreme targets;");
    $display("%0d results checked, %0d inside a ramp.", sb.checked, ramp_items);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb_profiled_ramp_value_generator: clean");
    end else begin
      $display("tb_profiled_ramp_value_generator: errors");
    end
    $finish;
  end
endmodule
